/* design/ctg_pkg.sv */
// ----------------------------------------------------------------------------
// ctg_pkg: shared types and constants for the cubic trajectory generator
// Pose and result payloads, plus the job record passed from front to back.
// ----------------------------------------------------------------------------
package ctg_pkg;

    localparam int POS_W  = 32;          // Q16.16 pose field
    localparam int DIFF_W = POS_W + 1;   // end minus start, no overflow
    localparam int IDX_W  = 6;           // point index / span
    localparam int CNT_W  = 7;           // point_count register

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd16;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_heading;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic signed [POS_W-1:0] end_heading;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        point_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_heading;
        logic                    last_point;
    } result_t;

    // One queued trajectory: start pose, per-axis span and point_count - 1
    typedef struct packed {
        logic signed [POS_W-1:0]  start_x;
        logic signed [POS_W-1:0]  start_y;
        logic signed [POS_W-1:0]  start_heading;
        logic signed [DIFF_W-1:0] diff_x;
        logic signed [DIFF_W-1:0] diff_y;
        logic signed [DIFF_W-1:0] diff_heading;
        logic [IDX_W-1:0]         span;
    } job_t;

endpackage

/* design/ctg_front.sv */
// ----------------------------------------------------------------------------
// ctg_front: command intake
// Takes a pose pair, forms the 33-bit axis differences and the clamped span,
// and holds the job until the queue has room.
// ----------------------------------------------------------------------------
module ctg_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ctg_pkg::in_item_t           pose,
    input  logic [ctg_pkg::CNT_W-1:0]   point_count,
    input  logic                        q_full,
    output logic                        push,
    output ctg_pkg::job_t               job
);
    import ctg_pkg::*;

    logic             job_valid_reg;
    logic             job_valid_next;
    job_t             job_reg;
    job_t             job_next;
    logic             accept;
    logic [CNT_W-1:0] n_eff;

    assign busy   = job_valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = job_valid_reg && !q_full;
    assign job    = job_reg;

    // counts below two act as two, above the maximum as the maximum
    always_comb
    begin
        if (point_count < CNT_W'(2))
            n_eff = CNT_W'(2);
        else if (point_count > CNT_W'(MAX_POINTS))
            n_eff = CNT_W'(MAX_POINTS);
        else
            n_eff = point_count;
    end

    always_comb
    begin
        job_next               = job_reg;
        job_next.start_x       = pose.start_x;
        job_next.start_y       = pose.start_y;
        job_next.start_heading = pose.start_heading;
        job_next.diff_x        = DIFF_W'($signed(pose.end_x))
                                 - DIFF_W'($signed(pose.start_x));
        job_next.diff_y        = DIFF_W'($signed(pose.end_y))
                                 - DIFF_W'($signed(pose.start_y));
        job_next.diff_heading  = DIFF_W'($signed(pose.end_heading))
                                 - DIFF_W'($signed(pose.start_heading));
        job_next.span          = IDX_W'(n_eff - CNT_W'(1));
    end

    always_comb
    begin
        if (accept)
            job_valid_next = 1'b1;
        else if (push)
            job_valid_next = 1'b0;
        else
            job_valid_next = job_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else
            job_valid_reg <= job_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

endmodule

/* design/ctg_queue.sv */
// ----------------------------------------------------------------------------
// ctg_queue: job queue
// Small register FIFO between intake and point generation.
// ----------------------------------------------------------------------------
module ctg_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ctg_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output ctg_pkg::job_t  head,
    output logic           empty
);
    import ctg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (occ_reg == OCC_W'(DEPTH));
    assign empty   = (occ_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            occ_next = occ_reg + OCC_W'(1);
        else if (do_pop && !do_push)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // intake only pushes into free space
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into a full queue");

endmodule

/* design/ctg_back.sv */
// ----------------------------------------------------------------------------
// ctg_back: point generator
// Bit-serial 2^F / span divide, then one point per cycle through a
// five-stage smoothstep and interpolation pipeline.
// ----------------------------------------------------------------------------
module ctg_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ctg_pkg::job_t     head,
    output logic              pop,
    output logic              result_strobe,
    output ctg_pkg::result_t  result
);
    import ctg_pkg::*;

    localparam int T_W  = FRAC_BITS + 1;          // t in [0, 1]
    localparam int SQ_W = 2 * FRAC_BITS + 1;      // t^2
    localparam int M_W  = FRAC_BITS + 2;          // 3 - 2t
    localparam int A_W  = T_W + M_W;
    localparam int B_W  = FRAC_BITS + M_W;
    localparam int P_W  = DIFF_W + FRAC_BITS + 2;
    localparam int DC_W = $clog2(FRAC_BITS + 1);

    localparam logic [M_W-1:0] THREE_ONE = M_W'(3) << FRAC_BITS;
    localparam logic [T_W-1:0] ONE_FIX   = T_W'(1) << FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    job_t              job_reg;
    logic [DC_W-1:0]   div_cnt_reg;
    logic [DC_W-1:0]   div_cnt_next;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;
    logic [T_W-1:0]    quo_reg;
    logic [T_W-1:0]    quo_next;
    logic [T_W-1:0]    t_reg;
    logic [T_W-1:0]    t_next;
    logic [IDX_W-1:0]  racc_reg;
    logic [IDX_W-1:0]  racc_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    logic [IDX_W:0]    rem_sh;
    logic              rem_ge;
    logic [IDX_W:0]    racc_sum;
    logic              carry;
    logic              issue;
    logic              issue_last;
    logic              pipe_busy;

    // pipeline
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]         idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic                     last1_reg, last2_reg, last3_reg, last4_reg;
    logic [2*T_W-1:0]         sq_full;
    logic [SQ_W-1:0]          sq1_reg;
    logic [M_W-1:0]           m1_reg;
    logic [A_W-1:0]           a2_reg;
    logic [B_W-1:0]           b2_reg;
    logic [A_W-1:0]           blend_sum;
    logic [T_W-1:0]           blend3_reg;
    logic signed [P_W-1:0]    px4_reg, py4_reg, ph4_reg;
    logic signed [P_W-1:0]    qx, qy, qh;
    logic                     strobe_reg;
    result_t                  result_reg;
    result_t                  result_next;

    assign pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign pop        = (state_reg == ST_IDLE) && !q_empty && !pipe_busy;
    assign issue      = (state_reg == ST_RUN);
    assign issue_last = (idx_reg == job_reg.span);

    // restoring divide of 2^F by span: dividend has a single one at the top
    assign rem_sh = {rem_reg, (div_cnt_reg == DC_W'(FRAC_BITS))};
    assign rem_ge = (rem_sh >= {1'b0, job_reg.span});

    // t accumulates quotient plus a carry from the remainder
    assign racc_sum = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign carry    = (racc_sum >= {1'b0, job_reg.span});

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        t_next       = t_reg;
        racc_next    = racc_reg;
        idx_next     = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next   = ST_DIV;
                    div_cnt_next = DC_W'(FRAC_BITS);
                    rem_next     = '0;
                    quo_next     = '0;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? IDX_W'(rem_sh - {1'b0, job_reg.span}) : IDX_W'(rem_sh);
                quo_next = {quo_reg[T_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg - DC_W'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_RUN;
                    t_next     = '0;
                    racc_next  = '0;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                racc_next = carry ? IDX_W'(racc_sum - {1'b0, job_reg.span}) : IDX_W'(racc_sum);
                t_next    = t_reg + quo_reg + T_W'(carry);
                idx_next  = idx_reg + IDX_W'(1);
                if (issue_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
        div_cnt_reg <= div_cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        t_reg       <= t_next;
        racc_reg    <= racc_next;
        idx_reg     <= idx_next;
    end

    // ---- smoothstep and interpolation pipeline ----
    assign sq_full   = (2*T_W)'(t_reg) * (2*T_W)'(t_reg);
    assign blend_sum = a2_reg + A_W'(b2_reg >> FRAC_BITS);

    // floor shift toward minus infinity
    assign qx = px4_reg >>> FRAC_BITS;
    assign qy = py4_reg >>> FRAC_BITS;
    assign qh = ph4_reg >>> FRAC_BITS;

    always_comb
    begin
        result_next.point_index = idx4_reg;
        result_next.pos_x       = job_reg.start_x + qx[POS_W-1:0];
        result_next.pos_y       = job_reg.start_y + qy[POS_W-1:0];
        result_next.pos_heading = job_reg.start_heading + qh[POS_W-1:0];
        result_next.last_point  = last4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            strobe_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg   <= idx_reg;
        last1_reg  <= issue_last;
        sq1_reg    <= sq_full[SQ_W-1:0];
        m1_reg     <= THREE_ONE - {t_reg, 1'b0};

        idx2_reg   <= idx1_reg;
        last2_reg  <= last1_reg;
        a2_reg     <= A_W'(sq1_reg[SQ_W-1:FRAC_BITS]) * A_W'(m1_reg);
        b2_reg     <= B_W'(sq1_reg[FRAC_BITS-1:0]) * B_W'(m1_reg);

        idx3_reg   <= idx2_reg;
        last3_reg  <= last2_reg;
        blend3_reg <= blend_sum[FRAC_BITS +: T_W];

        idx4_reg   <= idx3_reg;
        last4_reg  <= last3_reg;
        px4_reg    <= $signed({1'b0, blend3_reg}) * $signed(job_reg.diff_x);
        py4_reg    <= $signed({1'b0, blend3_reg}) * $signed(job_reg.diff_y);
        ph4_reg    <= $signed({1'b0, blend3_reg}) * $signed(job_reg.diff_heading);

        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // the divide of the next job always separates two runs
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.last_point |=> !strobe_reg)
        else $error("result straight after last point");

    // points of one run come on consecutive cycles with rising index
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !result_reg.last_point |=>
            strobe_reg && (result_reg.point_index == $past(result_reg.point_index)
                                                     + IDX_W'(1)))
        else $error("gap or index skip inside a run");

    // the accumulated t never passes one
    a_t_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (t_reg <= ONE_FIX))
        else $error("t accumulator above one");

endmodule

/* design/cubic_trajectory_generator.sv */
// ----------------------------------------------------------------------------
// cubic_trajectory_generator: smoothstep point generator
// Turns a start/end pose pair into point_count points along 3t^2 - 2t^3.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer a pose pair; the block replies
// with point_count results, one per cycle, each marked by result_strobe for a
// single cycle. There is no back-pressure on results: the receiver must take
// every strobed result as it comes. In the generator a transfer runs a
// bit-serial divide of 2^FRAC_BITS by point_count - 1, then produces one
// point per cycle, and lets the five-stage result pipeline drain before
// the next job is started. A two-deep job queue plus the intake register
// mean up to three pose pairs can wait behind the one being generated
// before busy rises. point_count is clamped to 2..MAX_POINTS, and should
// only be written while no job is outstanding.
// ----------------------------------------------------------------------------
module cubic_trajectory_generator #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ctg_pkg::in_item_t          pose,
    input  logic                       cfg_wr_en,
    input  logic [ctg_pkg::CNT_W-1:0]  cfg_wr_data,
    output logic                       result_strobe,
    output ctg_pkg::result_t           result
);
    import ctg_pkg::*;

    logic [CNT_W-1:0] point_count_reg;
    logic [CNT_W-1:0] point_count_next;

    // front to queue
    logic             push;
    job_t             push_job;
    logic             q_full;

    // queue to back
    logic             pop;
    job_t             head;
    logic             q_empty;

    // configuration: single register, plain write strobe
    assign point_count_next = cfg_wr_en ? cfg_wr_data : point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= COUNT_RESET;
        else
            point_count_reg <= point_count_next;
    end

    // intake: differences and clamped span worked out at transfer
    ctg_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pose        (pose),
        .point_count (point_count_reg),
        .q_full      (q_full),
        .push        (push),
        .job         (push_job)
    );

    // decouples intake from point generation
    ctg_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // divide, then one point per cycle
    ctg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule
